### hw/rtl/mersenne_twister_bounded_draw_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded-draw twister
// Concurrent checks that reduce to nothing in a synthesis build.
// ----------------------------------------------------------------------------
`ifndef MERSENNE_TWISTER_BOUNDED_DRAW_DEFINES_SVH
`define MERSENNE_TWISTER_BOUNDED_DRAW_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication
`define MTBD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mtbd check failed");

// Next-cycle implication
`define MTBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mtbd check failed");

`else

`define MTBD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`define MTBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### hw/rtl/mtbd_pkg.sv
// ----------------------------------------------------------------------------
// mtbd_pkg
// Types, constants and word functions shared by the bounded-draw twister.
// ----------------------------------------------------------------------------
package mtbd_pkg;

	localparam int WORD_W   = 32;
	localparam int CHOICE_W = 31;

	localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_B0DF;
	localparam logic [WORD_W-1:0] INIT_MULT    = 32'h6C07_8965;
	localparam logic [WORD_W-1:0] TEMPER_B     = 32'hFF3A_58AD;
	localparam logic [WORD_W-1:0] TEMPER_C     = 32'hFFFF_DF8C;

	// Request codes
	localparam logic REQ_SEED = 1'b0;
	localparam logic REQ_DRAW = 1'b1;

	typedef struct packed {
		logic                req_type;
		logic [WORD_W-1:0]   seed_value;
		logic [CHOICE_W-1:0] range_max;
	} mtbd_req_t;

	typedef struct packed {
		logic [WORD_W-1:0]   raw_word;
		logic [CHOICE_W-1:0] choice;
	} mtbd_rsp_t;

	// Request to the remainder unit
	typedef struct packed {
		logic                start;
		logic [CHOICE_W-1:0] dividend;
		logic [CHOICE_W-1:0] divisor;
	} mtbd_div_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED_MUL,
		ST_SEED_ADD,
		ST_RD_NXT,
		ST_RD_FAR,
		ST_TWIST,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_LOAD
	} mtbd_state_t;

	// One step of the twist recurrence
	function automatic logic [WORD_W-1:0] twist_word(
		input logic [WORD_W-1:0] cur,
		input logic [WORD_W-1:0] nxt,
		input logic [WORD_W-1:0] far
	);
		logic [WORD_W-1:0] y;
		y = {cur[WORD_W-1], nxt[WORD_W-2:0]};
		return far ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : '0);
	endfunction

	// Output tempering
	function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] y;
		y = w;
		y = y ^ (y >> 11);
		y = y ^ ((y & TEMPER_B) << 7);
		y = y ^ ((y & TEMPER_C) << 15);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

### hw/rtl/mtbd_stream_if.sv
// ----------------------------------------------------------------------------
// mtbd_stream_if
// Valid/ready channel carrying one payload struct per transfer.
// ----------------------------------------------------------------------------
interface mtbd_stream_if #(
	parameter type payload_t = logic
) ();

	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

### hw/rtl/mtbd_ram.sv
// ----------------------------------------------------------------------------
// mtbd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mtbd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 624
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### hw/rtl/mtbd_mod.sv
// ----------------------------------------------------------------------------
// mtbd_mod
// Restoring remainder unit, one dividend bit per cycle. A zero divisor
// leaves the dividend as the remainder.
// ----------------------------------------------------------------------------
module mtbd_mod (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mtbd_pkg::mtbd_div_req_t         div_req,
	output logic                            done,
	output logic [mtbd_pkg::CHOICE_W-1:0]   rem
);

	import mtbd_pkg::*;

	localparam int CNT_W = $clog2(CHOICE_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CHOICE_W - 1);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CHOICE_W-1:0] dvd_q;
	logic [CHOICE_W-1:0] dvs_q;
	logic [CHOICE_W-1:0] rem_q;
	logic [CHOICE_W:0]   trial;
	logic [CHOICE_W:0]   dvs_ext;
	logic [CHOICE_W-1:0] rem_nx;

	// Shift in the next dividend bit and subtract where it fits
	always_comb begin
		trial   = {rem_q, dvd_q[CHOICE_W-1]};
		dvs_ext = {1'b0, dvs_q};
		if (trial >= dvs_ext) begin
			rem_nx = CHOICE_W'(trial - dvs_ext);
		end else begin
			rem_nx = trial[CHOICE_W-1:0];
		end
	end

	// Sequence control; flag done for one cycle after the last bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q & !div_req.start & (cnt_q == '0);
			if (div_req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_LAST;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Operand and partial remainder; hold the remainder once finished
	always_ff @(posedge clk) begin
		if (div_req.start) begin
			dvd_q <= div_req.dividend;
			dvs_q <= div_req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			dvd_q <= {dvd_q[CHOICE_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

### hw/rtl/mersenne_twister_bounded_draw.sv
// ----------------------------------------------------------------------------
// mersenne_twister_bounded_draw
// 32-bit Mersenne Twister with a bounded draw. The store is twisted one word
// per draw, just before that word is tempered; a 31-bit remainder unit
// reduces the draw to the requested range.
// ----------------------------------------------------------------------------
// Seed: one shared 32x32 multiply per word.
// Draw: three store reads, one twist step and the bit-serial remainder.
// One request is in work at a time; a finished result waits in an output
//   register while the next request is taken.
// Reset: index zero, store treated as all zeros until the first seed.
module mersenne_twister_bounded_draw #(
	parameter int STATE_WORDS  = 624,
	parameter int TWIST_OFFSET = 397
) (
	input  logic                 clk,
	input  logic                 arst_n,
	mtbd_stream_if.sink          req,
	mtbd_stream_if.source        rsp
);

	import mtbd_pkg::*;

	`include "mersenne_twister_bounded_draw_defines.svh"

	localparam int IDX_W = $clog2(STATE_WORDS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);
	localparam logic [IDX_W-1:0] FAR_OFF  = IDX_W'(TWIST_OFFSET);
	localparam logic [IDX_W-1:0] FAR_BACK = IDX_W'(STATE_WORDS - TWIST_OFFSET);

	mtbd_state_t state_q, state_d;

	logic                seeded_q;
	logic [IDX_W-1:0]    idx_q;
	logic [WORD_W-1:0]   prev_q;
	logic [WORD_W-1:0]   prod_q;
	logic [WORD_W-1:0]   cur_q;
	logic [WORD_W-1:0]   nxt_q;
	logic [WORD_W-1:0]   raw_q;
	logic [CHOICE_W-1:0] range_q;
	logic                rsp_valid_q;
	mtbd_rsp_t           rsp_q;

	logic                req_xfer;
	logic                rsp_xfer;
	logic                out_free;
	logic [IDX_W-1:0]    nxt_idx;
	logic [IDX_W-1:0]    far_idx;
	logic [WORD_W-1:0]   seed_word;
	logic [WORD_W-1:0]   twisted;
	logic [WORD_W-1:0]   mix;

	logic                mem_wr_en;
	logic [IDX_W-1:0]    mem_wr_addr;
	logic [WORD_W-1:0]   mem_wr_data;
	logic [IDX_W-1:0]    mem_rd_addr;
	logic [WORD_W-1:0]   mem_rd_data;

	mtbd_div_req_t       div_req;
	logic                div_done;
	logic [CHOICE_W-1:0] div_rem;

	assign req_xfer = req.valid & req.ready;
	assign rsp_xfer = rsp_valid_q & rsp.ready;
	assign out_free = !rsp_valid_q | rsp.ready;

	// Neighbour addresses of the current word
	assign nxt_idx = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
	assign far_idx = (idx_q < FAR_BACK) ? idx_q + FAR_OFF : idx_q - FAR_BACK;

	// Seed recurrence and twist step
	assign mix       = prev_q ^ (prev_q >> 30);
	assign seed_word = prod_q + WORD_W'(idx_q);
	assign twisted   = twist_word(cur_q, nxt_q, mem_rd_data);

	mtbd_ram #(
		.WIDTH (WORD_W),
		.DEPTH (STATE_WORDS)
	) u_store (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	mtbd_mod u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.div_req (div_req),
		.done    (div_done),
		.rem     (div_rem)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_xfer) begin
					state_d = (req.data.req_type == REQ_SEED) ? ST_SEED_MUL : ST_RD_NXT;
				end
			end
			ST_SEED_MUL: state_d = ST_SEED_ADD;
			ST_SEED_ADD: state_d = (idx_q == LAST_IDX) ? ST_IDLE : ST_SEED_MUL;
			ST_RD_NXT:   state_d = ST_RD_FAR;
			ST_RD_FAR:   state_d = ST_TWIST;
			ST_TWIST:    state_d = ST_DIV_GO;
			ST_DIV_GO:   state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// Store and unit controls
	always_comb begin
		req.ready        = 1'b0;
		mem_wr_en        = 1'b0;
		mem_wr_addr      = idx_q;
		mem_wr_data      = seed_word;
		mem_rd_addr      = idx_q;
		div_req.start    = 1'b0;
		div_req.dividend = raw_q[CHOICE_W-1:0];
		div_req.divisor  = range_q;
		case (state_q)
			ST_IDLE: begin
				req.ready   = 1'b1;
				mem_wr_en   = req.valid & (req.data.req_type == REQ_SEED);
				mem_wr_addr = '0;
				mem_wr_data = req.data.seed_value;
			end
			ST_SEED_ADD: mem_wr_en = 1'b1;
			ST_RD_NXT:   mem_rd_addr = nxt_idx;
			ST_RD_FAR:   mem_rd_addr = far_idx;
			ST_TWIST: begin
				mem_wr_en   = seeded_q;
				mem_wr_data = twisted;
			end
			ST_DIV_GO:   div_req.start = 1'b1;
			default: begin
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seeded_q    <= 1'b0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// Raise valid on a load, drop it on a transfer
			if (state_q == ST_LOAD && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_xfer) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_xfer && req.data.req_type == REQ_SEED) begin
						idx_q <= IDX_W'(1);
					end
				end
				ST_SEED_ADD: begin
					idx_q <= nxt_idx;
					if (idx_q == LAST_IDX) begin
						seeded_q <= 1'b1;
					end
				end
				ST_LOAD: begin
					if (out_free) begin
						idx_q <= nxt_idx;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				prev_q  <= req.data.seed_value;
				range_q <= req.data.range_max;
			end
			ST_SEED_MUL: prod_q <= mix * INIT_MULT;
			ST_SEED_ADD: prev_q <= seed_word;
			ST_RD_NXT:   cur_q  <= mem_rd_data;
			ST_RD_FAR:   nxt_q  <= mem_rd_data;
			// an unseeded store is treated as all zeros, so the draw is zero
			ST_TWIST:    raw_q  <= seeded_q ? temper(twisted) : '0;
			ST_LOAD: begin
				if (out_free) begin
					rsp_q.raw_word <= raw_q;
					rsp_q.choice   <= div_rem;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// Checks
	`MTBD_ASSERT_IMPL(a_idx_range, clk, arst_n, 1'b1, idx_q <= LAST_IDX)
	`MTBD_ASSERT_IMPL(a_div_done_wait, clk, arst_n, div_done, state_q == ST_DIV_WAIT)
	`MTBD_ASSERT_NEXT(a_load_holds, clk, arst_n, state_q == ST_LOAD && rsp_valid_q && !rsp.ready, state_q == ST_LOAD)
	`MTBD_ASSERT_IMPL(a_unseeded_zero, clk, arst_n, rsp_valid_q && !seeded_q, rsp_q.raw_word == '0 && rsp_q.choice == '0)

endmodule
